>>> rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion helpers; compiled out when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// property checked at every rising edge outside reset
`define ASSERT_ALWAYS(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// antecedent in one cycle implies consequent in the next
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`else

`define ASSERT_ALWAYS(lbl, clk, rst_n, prop, msg)
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)

`endif

`endif

>>> rtl/twt_pkg.sv
// ----------------------------------------------------------------------------
// twt_pkg
// Shared types and constants of the trie word tokenizer.
// ----------------------------------------------------------------------------
`default_nettype none

package twt_pkg;

  localparam int unsigned ALPHA_SIZE      = 26;
  localparam int unsigned DEF_NODE_COUNT  = 4096;
  localparam int unsigned DEF_QUEUE_DEPTH = 4;
  localparam int unsigned OUT_DEPTH       = 4;  // power of two

  localparam logic [31:0] NO_TOKEN  = 32'hFFFF_FFFF;
  localparam logic [7:0]  WORDS_MAX = 8'hFF;

  localparam logic [7:0] CH_A     = 8'h61;
  localparam logic [7:0] CH_Z     = 8'h7A;
  localparam logic [7:0] CH_COMMA = 8'h2C;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_CR    = 8'h0D;

  typedef enum logic [1:0] {
    CMD_LOAD_CHILD = 2'd0,
    CMD_LOAD_LOC   = 2'd1,
    CMD_TEXT       = 2'd2,
    CMD_NOP        = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    OP_WR_CHILD = 2'd0,
    OP_WR_LOC   = 2'd1,
    OP_LETTER   = 2'd2,
    OP_END      = 2'd3
  } op_e;

  typedef enum logic {
    RES_WORD = 1'b0,
    RES_CELL = 1'b1
  } kind_e;

  // one classified item between front and back
  typedef struct packed {
    op_e         op;
    logic [11:0] node;
    logic [4:0]  slot;
    logic [11:0] child;
    logic [31:0] value;
    logic        close_cell;
    logic        row_end;
  } work_t;

  typedef struct packed {
    kind_e       kind;
    logic [31:0] id;
    logic        found;
    logic [7:0]  words;
    logic        row_end;
    logic        last;
  } result_t;

endpackage

`default_nettype wire

>>> rtl/twt_ram.sv
// ----------------------------------------------------------------------------
// twt_ram
// Simple dual-port RAM, one write and one read port, registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module twt_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16,
  localparam int unsigned AW   = $clog2(DEPTH)
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic             re_i,
  input  wire logic [AW-1:0]    raddr_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

>>> rtl/twt_fifo.sv
// ----------------------------------------------------------------------------
// twt_fifo
// Small first-word-fall-through queue in flip-flops.
// ----------------------------------------------------------------------------
`default_nettype none

module twt_fifo #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 4,
  localparam int unsigned PW   = (DEPTH > 1) ? $clog2(DEPTH) : 1,
  localparam int unsigned CW   = $clog2(DEPTH + 1)
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             in_valid_i,
  output logic                  in_ready_o,
  input  wire logic [WIDTH-1:0] in_data_i,
  output logic                  out_valid_o,
  input  wire logic             out_ready_i,
  output logic      [WIDTH-1:0] out_data_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [PW-1:0]    wptr_q, wptr_d, rptr_q, rptr_d;
  logic [CW-1:0]    cnt_q, cnt_d;
  logic             push, pop;

  assign in_ready_o  = (cnt_q != CW'(DEPTH));
  assign out_valid_o = (cnt_q != '0);
  assign out_data_o  = mem_q[rptr_q];
  assign push        = in_valid_i && in_ready_o;
  assign pop         = out_valid_o && out_ready_i;

  always_comb begin
    wptr_d = wptr_q;
    rptr_d = rptr_q;
    cnt_d  = cnt_q;
    if (push) begin
      wptr_d = (wptr_q == PW'(DEPTH - 1)) ? '0 : PW'(wptr_q + 1'b1);
    end
    if (pop) begin
      rptr_d = (rptr_q == PW'(DEPTH - 1)) ? '0 : PW'(rptr_q + 1'b1);
    end
    if (push && !pop) begin
      cnt_d = CW'(cnt_q + 1'b1);
    end else if (pop && !push) begin
      cnt_d = CW'(cnt_q - 1'b1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wptr_q] <= in_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

endmodule

`default_nettype wire

>>> rtl/twt_front.sv
// ----------------------------------------------------------------------------
// twt_front
// Accepts commands, drops no-ops, bad loads and an LF after CR, classifies.
// ----------------------------------------------------------------------------
`default_nettype none

module twt_front
  import twt_pkg::*;
#(
  parameter int unsigned NODE_COUNT = DEF_NODE_COUNT
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic [1:0]  in_cmd_i,
  input  wire logic [11:0] in_node_i,
  input  wire logic [4:0]  in_slot_i,
  input  wire logic [11:0] in_child_i,
  input  wire logic [31:0] in_value_i,
  input  wire logic [7:0]  in_byte_i,
  output logic             q_valid_o,
  input  wire logic        q_ready_i,
  output work_t            q_data_o
);

  logic  after_cr_q, after_cr_d;
  logic  keep;
  logic  node_ok;
  logic  accept;
  cmd_e  cmd;

  assign cmd     = cmd_e'(in_cmd_i);
  assign node_ok = ({20'b0, in_node_i} < 32'(NODE_COUNT));
  assign accept  = in_valid_i && in_ready_o;

  assign in_ready_o = q_ready_i;
  assign q_valid_o  = in_valid_i && keep;

  always_comb begin
    keep                = 1'b0;
    after_cr_d          = after_cr_q;
    q_data_o            = '0;
    q_data_o.node       = in_node_i;
    q_data_o.slot       = in_slot_i;
    q_data_o.child      = in_child_i;
    q_data_o.value      = in_value_i;
    q_data_o.op         = OP_END;
    unique case (cmd)
      CMD_LOAD_CHILD: begin
        q_data_o.op = OP_WR_CHILD;
        keep        = node_ok && (in_slot_i < 5'(ALPHA_SIZE));
      end
      CMD_LOAD_LOC: begin
        q_data_o.op = OP_WR_LOC;
        keep        = node_ok;
      end
      CMD_TEXT: begin
        after_cr_d = (in_byte_i == CH_CR);
        if (after_cr_q && in_byte_i == CH_LF) begin
          after_cr_d = 1'b0;  // second half of CR LF
        end else if (in_byte_i >= CH_A && in_byte_i <= CH_Z) begin
          keep          = 1'b1;
          q_data_o.op   = OP_LETTER;
          q_data_o.slot = 5'(in_byte_i - CH_A);
        end else begin
          keep                = 1'b1;
          q_data_o.close_cell = (in_byte_i == CH_COMMA) || (in_byte_i == CH_CR) ||
                                (in_byte_i == CH_LF);
          q_data_o.row_end    = (in_byte_i == CH_CR) || (in_byte_i == CH_LF);
        end
      end
      CMD_NOP: begin
        keep = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      after_cr_q <= 1'b0;
    end else if (accept && cmd == CMD_TEXT) begin
      after_cr_q <= after_cr_d;
    end
  end

endmodule

`default_nettype wire

>>> rtl/twt_back.sv
// ----------------------------------------------------------------------------
// twt_back
// Walks the trie, writes the tables and buffers the results.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module twt_back
  import twt_pkg::*;
#(
  parameter int unsigned NODE_COUNT = DEF_NODE_COUNT
) (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  input  wire logic  q_valid_i,
  output logic       q_ready_o,
  input  wire work_t q_data_i,
  output logic       res_valid_o,
  input  wire logic  res_ready_i,
  output result_t    res_data_o
);

  localparam int unsigned CHILD_DEPTH = NODE_COUNT * ALPHA_SIZE;
  localparam int unsigned CAW         = $clog2(CHILD_DEPTH);
  localparam int unsigned NAW         = $clog2(NODE_COUNT);
  localparam int unsigned OPW         = $clog2(OUT_DEPTH);
  localparam int unsigned OCW         = $clog2(OUT_DEPTH + 1);

  // results still owed by the item issued last cycle
  typedef struct packed {
    logic       word_v;
    logic       word_miss;
    logic       cell_v;
    logic [7:0] cell_words;
    logic       cell_row_end;
  } pend_t;

  function automatic logic [31:0] child_index(logic [11:0] node, logic [4:0] slot);
    child_index = {20'b0, node} * 32'(ALPHA_SIZE) + {27'b0, slot};
  endfunction

  // walk state
  logic [11:0] cur_node_q, cur_node_d;
  logic        missed_q, missed_d;
  logic        inside_q, inside_d;
  logic        rd_pend_q, rd_pend_d;
  logic [7:0]  words_q, words_d;
  pend_t       pend_q, pend_d;

  // tables
  logic           child_we, child_re, loc_we, loc_re;
  logic [CAW-1:0] child_waddr, child_raddr;
  logic [NAW-1:0] loc_waddr, loc_raddr;
  logic [11:0]    child_rd;
  logic [31:0]    loc_rd;
  logic [31:0]    wr_idx, rd_idx, wr_node_ext, eff_node_ext;

  logic [11:0] eff_node, base_node;
  logic        eff_missed, base_missed, child_bad;
  logic [7:0]  word_cnt;
  logic        room, issue;

  // result buffer
  result_t      obuf_q [OUT_DEPTH];
  logic [OPW-1:0] owptr_q, orptr_q;
  logic [OCW-1:0] occ_q;
  logic [1:0]   r1_n;
  logic         pop, hit;
  result_t      word_res, cell_res;

  // resolve the child read issued last cycle
  assign child_bad = (child_rd == '0) || ({20'b0, child_rd} >= 32'(NODE_COUNT));

  always_comb begin
    eff_node   = cur_node_q;
    eff_missed = missed_q;
    if (rd_pend_q) begin
      if (child_bad) begin
        eff_missed = 1'b1;
      end else begin
        eff_node = child_rd;
      end
    end
  end

  assign base_node   = inside_q ? eff_node : '0;
  assign base_missed = inside_q && eff_missed;
  assign word_cnt    = (inside_q && words_q != WORDS_MAX) ? 8'(words_q + 1'b1) : words_q;

  assign r1_n  = 2'(pend_q.word_v) + 2'(pend_q.cell_v);
  // an end item may owe two results; keep room for them and for those in flight
  assign room  = ((OCW + 1)'(occ_q) + (OCW + 1)'(r1_n) + (OCW + 1)'(2))
                 <= (OCW + 1)'(OUT_DEPTH);
  assign q_ready_o = (q_data_i.op != OP_END) || room;
  assign issue     = q_valid_i && q_ready_o;

  assign wr_idx       = child_index(q_data_i.node, q_data_i.slot);
  assign rd_idx       = child_index(base_node, q_data_i.slot);
  assign wr_node_ext  = {20'b0, q_data_i.node};
  assign eff_node_ext = {20'b0, eff_node};
  assign child_waddr  = wr_idx[CAW-1:0];
  assign child_raddr  = rd_idx[CAW-1:0];
  assign loc_waddr    = wr_node_ext[NAW-1:0];
  assign loc_raddr    = eff_node_ext[NAW-1:0];

  always_comb begin
    cur_node_d = eff_node;
    missed_d   = eff_missed;
    inside_d   = inside_q;
    words_d    = words_q;
    rd_pend_d  = 1'b0;
    pend_d     = '0;
    child_we   = 1'b0;
    child_re   = 1'b0;
    loc_we     = 1'b0;
    loc_re     = 1'b0;
    if (issue) begin
      unique case (q_data_i.op)
        OP_WR_CHILD: begin
          child_we = 1'b1;
        end
        OP_WR_LOC: begin
          loc_we = 1'b1;
        end
        OP_LETTER: begin
          inside_d   = 1'b1;
          cur_node_d = base_node;
          missed_d   = base_missed;
          if (!base_missed) begin
            child_re  = 1'b1;
            rd_pend_d = 1'b1;
          end
        end
        OP_END: begin
          if (inside_q) begin
            loc_re           = 1'b1;
            pend_d.word_v    = 1'b1;
            pend_d.word_miss = eff_missed;
            inside_d         = 1'b0;
            missed_d         = 1'b0;
            cur_node_d       = '0;
          end
          words_d = word_cnt;
          if (q_data_i.close_cell) begin
            pend_d.cell_v       = 1'b1;
            pend_d.cell_words   = word_cnt;
            pend_d.cell_row_end = q_data_i.row_end;
            words_d             = '0;
          end
        end
      endcase
    end
  end

  twt_ram #(
    .WIDTH (12),
    .DEPTH (CHILD_DEPTH)
  ) u_child_ram (
    .clk_i   (clk_i),
    .we_i    (child_we),
    .waddr_i (child_waddr),
    .wdata_i (q_data_i.child),
    .re_i    (child_re),
    .raddr_i (child_raddr),
    .rdata_o (child_rd)
  );

  twt_ram #(
    .WIDTH (32),
    .DEPTH (NODE_COUNT)
  ) u_loc_ram (
    .clk_i   (clk_i),
    .we_i    (loc_we),
    .waddr_i (loc_waddr),
    .wdata_i (q_data_i.value),
    .re_i    (loc_re),
    .raddr_i (loc_raddr),
    .rdata_o (loc_rd)
  );

  // form results from the location read
  assign hit = !pend_q.word_miss && (loc_rd != NO_TOKEN);

  always_comb begin
    word_res         = '0;
    word_res.kind    = RES_WORD;
    word_res.id      = hit ? loc_rd : NO_TOKEN;
    word_res.found   = hit;
    word_res.last    = !pend_q.cell_v;
    cell_res         = '0;
    cell_res.kind    = RES_CELL;
    cell_res.words   = pend_q.cell_words;
    cell_res.row_end = pend_q.cell_row_end;
    cell_res.last    = 1'b1;
  end

  assign res_valid_o = (occ_q != '0);
  assign res_data_o  = obuf_q[orptr_q];
  assign pop         = res_valid_o && res_ready_i;

  always_ff @(posedge clk_i) begin
    if (pend_q.word_v) begin
      obuf_q[owptr_q] <= word_res;
    end
    if (pend_q.cell_v) begin
      obuf_q[pend_q.word_v ? OPW'(owptr_q + 1'b1) : owptr_q] <= cell_res;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_node_q <= '0;
      missed_q   <= 1'b0;
      inside_q   <= 1'b0;
      rd_pend_q  <= 1'b0;
      words_q    <= '0;
      pend_q     <= '0;
      owptr_q    <= '0;
      orptr_q    <= '0;
      occ_q      <= '0;
    end else begin
      cur_node_q <= cur_node_d;
      missed_q   <= missed_d;
      inside_q   <= inside_d;
      rd_pend_q  <= rd_pend_d;
      words_q    <= words_d;
      pend_q     <= pend_d;
      owptr_q    <= OPW'(owptr_q + OPW'(r1_n));  // depth is a power of two
      orptr_q    <= OPW'(orptr_q + OPW'(pop));
      occ_q      <= OCW'(occ_q + OCW'(r1_n) - OCW'(pop));
    end
  end

  `ASSERT_ALWAYS(a_obuf_bound, clk_i, rst_ni, occ_q <= OCW'(OUT_DEPTH), "result buffer overrun")
  `ASSERT_ALWAYS(a_rd_in_word, clk_i, rst_ni, !rd_pend_q || inside_q, "child read outside word")
  `ASSERT_NEXT(a_word_res, clk_i, rst_ni, issue && q_data_i.op == OP_END && inside_q,
               pend_q.word_v, "word end without word result")
  `ASSERT_NEXT(a_pop_empty, clk_i, rst_ni, occ_q == '0 && r1_n == 2'd0,
               occ_q == '0, "result buffer count drift")

endmodule

`default_nettype wire

>>> rtl/trie_word_tokenizer.sv
// ----------------------------------------------------------------------------
// trie_word_tokenizer
// CSV word tokenizer: lower-case words walk a trie held in two on-chip tables.
// ----------------------------------------------------------------------------
// Throughput: one input transfer per cycle while the work queue has room;
//   each letter does one child-table read, and its registered data forms
//   the next letter's read address. A result passes the work queue, the
//   walk/issue stage with the location read, then the result buffer write.
// A byte that yields two results sends them as two output transfers, tlast on
//   the second.
// Reset: asynchronous, active low; clears walk state and queues. The tables
//   are not cleared and must be loaded before text is sent.
// ----------------------------------------------------------------------------
`default_nettype none

module trie_word_tokenizer
  import twt_pkg::*;
#(
  parameter int unsigned NODE_COUNT  = DEF_NODE_COUNT,
  parameter int unsigned QUEUE_DEPTH = DEF_QUEUE_DEPTH
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // input stream
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  // tdata, low bit up: node_number[11:0], letter_slot[16:12], child_number[28:17],
  //   token_value[60:29], text_byte[68:61], zero fill[71:69]
  input  wire logic [71:0] s_axis_tdata,
  // tuser: command[1:0]
  input  wire logic [1:0]  s_axis_tuser,
  // result stream
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  // tdata, low bit up: token_id[31:0], token_found[32], cell_words[40:33],
  //   row_end[41], zero fill[47:42]
  output logic      [47:0] m_axis_tdata,
  // tuser: result_kind[0]
  output logic             m_axis_tuser,
  // tlast: last result caused by one input transfer
  output logic             m_axis_tlast
);

  // front -> queue
  logic  fq_valid, fq_ready;
  work_t fq_data;
  // queue -> back
  logic  qb_valid, qb_ready;
  work_t qb_data;
  // back -> output
  result_t res;

  // Front: classifies each transfer; no-ops, out-of-range loads and the LF of
  // a CR LF pair are taken and dropped here.
  twt_front #(
    .NODE_COUNT (NODE_COUNT)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .in_cmd_i   (s_axis_tuser),
    .in_node_i  (s_axis_tdata[11:0]),
    .in_slot_i  (s_axis_tdata[16:12]),
    .in_child_i (s_axis_tdata[28:17]),
    .in_value_i (s_axis_tdata[60:29]),
    .in_byte_i  (s_axis_tdata[68:61]),
    .q_valid_o  (fq_valid),
    .q_ready_i  (fq_ready),
    .q_data_o   (fq_data)
  );

  // Work queue decouples input acceptance from result back-pressure.
  twt_fifo #(
    .WIDTH ($bits(work_t)),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (fq_valid),
    .in_ready_o  (fq_ready),
    .in_data_i   (fq_data),
    .out_valid_o (qb_valid),
    .out_ready_i (qb_ready),
    .out_data_o  (qb_data)
  );

  // Back: trie walk, table writes and result buffer.
  twt_back #(
    .NODE_COUNT (NODE_COUNT)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_valid_i   (qb_valid),
    .q_ready_o   (qb_ready),
    .q_data_i    (qb_data),
    .res_valid_o (m_axis_tvalid),
    .res_ready_i (m_axis_tready),
    .res_data_o  (res)
  );

  assign m_axis_tdata = {6'b0, res.row_end, res.words, res.found, res.id};
  assign m_axis_tuser = res.kind;
  assign m_axis_tlast = res.last;

endmodule

`default_nettype wire
